>>> src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int PRI_W    = 8;
  localparam int OCC_W    = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP_HI = 2'd1,
    OP_POP_LO = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/spq_if.sv
// Handshake channel interfaces for operation words and result words.
interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [spq_pkg::ID_W-1:0]      item_id;
  logic [spq_pkg::PRI_W-1:0]     priority_req;
  modport source (output valid, op, item_id, priority_req, input ready);
  modport sink   (input valid, op, item_id, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::ID_W-1:0]      out_id;
  logic [spq_pkg::PRI_W-1:0]     out_priority;
  logic [1:0]                    status;
  logic [spq_pkg::OCC_W-1:0]     occupancy;
  modport source (output valid, out_id, out_priority, status, occupancy, input ready);
  modport sink   (input valid, out_id, out_priority, status, occupancy, output ready);
endinterface

>>> src/spq_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module spq_ram #(
  parameter int ADDR_W = 5,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/sorted_priority_queue.sv
// Sorted priority queue: entries are held in a RAM in descending priority
// order (first-in-first-out among equal priorities). One operation word is
// taken at a time. Insert walks from the tail toward the head, shifting
// lower-priority entries down one place; pop-highest and remove-by-id walk
// from the head, closing the gap behind the removed entry; pop-lowest reads
// only the tail. Each visited entry takes a RAM read, then the
// read-modify-write step. The result word sits in an output register, so
// the next word is taken while a result waits. No clearing pass follows
// reset.
module sorted_priority_queue (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_w,
  spq_out_if.source out_w
);
  import spq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_PR, S_INS, S_FIN} state_t;

  state_t              state_r;
  op_t                 op_r;
  logic [ID_W-1:0]     id_r;
  logic [PRI_W-1:0]    pri_r;
  logic [CNT_W-1:0]    k_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                found_r;
  entry_t              res_r;
  status_t             res_st_r;
  logic                out_valid_r;
  entry_t              out_ent_r;
  status_t             out_st_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0]  rd_raw;
  entry_t              rd_ent;
  logic                match;
  logic [CNT_W-1:0]    k_dec;
  logic [CNT_W-1:0]    k_inc;

  assign rd_ent = entry_t'(rd_raw);
  assign k_dec  = k_r - CNT_W'(1);
  assign k_inc  = k_r + CNT_W'(1);
  assign match  = (op_r == OP_POP_HI) ? (k_r == '0) : (rd_ent.id == id_r);

  spq_ram #(.ADDR_W(ADDR_W), .DATA_W(ENTRY_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    rd_en   = (state_r == S_RD);
    rd_addr = (op_r == OP_INSERT) ? k_dec[ADDR_W-1:0] : k_r[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = k_r[ADDR_W-1:0];
    wr_data = rd_ent;
    case (state_r)
      S_INS: begin
        wr_en   = 1'b1;
        wr_data = '{id: id_r, pri: pri_r};
      end
      S_PR: begin
        case (op_r)
          OP_INSERT: begin
            wr_en = 1'b1;
            if (rd_ent.pri >= pri_r) begin
              wr_data = '{id: id_r, pri: pri_r};
            end
          end
          OP_POP_HI, OP_REMOVE: begin
            wr_en   = found_r;
            wr_addr = k_dec[ADDR_W-1:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign in_w.ready         = (state_r == S_IDLE);
  assign out_w.valid        = out_valid_r;
  assign out_w.out_id       = out_ent_r.id;
  assign out_w.out_priority = out_ent_r.pri;
  assign out_w.status       = out_st_r;
  assign out_w.occupancy    = out_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_w.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_w.valid) begin
            op_r    <= op_t'(in_w.op);
            id_r    <= in_w.item_id;
            pri_r   <= in_w.priority_req;
            found_r <= 1'b0;
            res_r   <= '0;
            res_st_r <= ST_MISS;
            case (op_t'(in_w.op))
              OP_INSERT: begin
                k_r <= cnt_r;
                if (cnt_r == CNT_W'(CAPACITY)) begin
                  res_r    <= '{id: in_w.item_id, pri: in_w.priority_req};
                  res_st_r <= ST_FULL;
                  state_r  <= S_FIN;
                end else if (cnt_r == '0) begin
                  state_r <= S_INS;
                end else begin
                  state_r <= S_RD;
                end
              end
              OP_POP_LO: begin
                k_r     <= cnt_r - CNT_W'(1);
                state_r <= (cnt_r == '0) ? S_FIN : S_RD;
              end
              default: begin
                k_r     <= '0;
                state_r <= (cnt_r == '0) ? S_FIN : S_RD;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_PR;
        end
        S_PR: begin
          case (op_r)
            OP_INSERT: begin
              if (rd_ent.pri >= pri_r) begin
                cnt_r    <= cnt_r + CNT_W'(1);
                res_r    <= '{id: id_r, pri: pri_r};
                res_st_r <= ST_OK;
                state_r  <= S_FIN;
              end else begin
                k_r     <= k_dec;
                state_r <= (k_dec == '0) ? S_INS : S_RD;
              end
            end
            OP_POP_LO: begin
              cnt_r    <= cnt_r - CNT_W'(1);
              res_r    <= rd_ent;
              res_st_r <= ST_OK;
              state_r  <= S_FIN;
            end
            default: begin
              if (!found_r && match) begin
                found_r  <= 1'b1;
                res_r    <= rd_ent;
                res_st_r <= ST_OK;
              end
              k_r <= k_inc;
              if (k_inc == cnt_r) begin
                if (found_r || match) begin
                  cnt_r <= cnt_r - CNT_W'(1);
                end
                state_r <= S_FIN;
              end else begin
                state_r <= S_RD;
              end
            end
          endcase
        end
        S_INS: begin
          cnt_r    <= cnt_r + CNT_W'(1);
          res_r    <= '{id: id_r, pri: pri_r};
          res_st_r <= ST_OK;
          state_r  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_w.ready) begin
            out_valid_r <= 1'b1;
            out_ent_r   <= res_r;
            out_st_r    <= res_st_r;
            out_occ_r   <= OCC_W'(cnt_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FULL) |-> (out_occ_r == OCC_W'(CAPACITY)))
    else $error("full status with queue not full");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_w.valid && in_w.ready) |=> (state_r != S_IDLE))
    else $error("accepted word left no work");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_MISS) |-> (out_ent_r == '0))
    else $error("miss result carries data");

endmodule

>>> test/spq_tb_pkg.sv
// Testbench constants used by the watchdog in the testbench top.
package spq_tb_pkg;
  localparam int WATCHDOG_LIMIT = 20000;
endpackage

>>> test/spq_tb_if.sv
// Testbench-side copies are not needed; the RTL interfaces are reused directly.
package spq_tb_if_pkg;
  localparam int DRAIN_CYCLES = 200;
endpackage

>>> test/spq_checker.sv
// Checker: watches both channels, models the queue, compares result words.
module spq_checker
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  spq_in_if        in_w,
  spq_out_if       out_w,
  output int       fail_count,
  output int       pending
);

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    status_t          st;
    logic [OCC_W-1:0] occ;
  } result_t;

  logic [ID_W-1:0]  q_id [$];
  logic [PRI_W-1:0] q_pri [$];
  result_t          expected_words [$];

  function automatic result_t apply_op(op_t op, logic [ID_W-1:0] id,
                                       logic [PRI_W-1:0] pri);
    result_t r;
    int pos;
    r.id = '0;
    r.pri = '0;
    r.st = ST_MISS;
    case (op)
      OP_INSERT: begin
        r.id = id;
        r.pri = pri;
        if (q_id.size() >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < q_pri.size() && q_pri[pos] >= pri) pos++;
          q_id.insert(pos, id);
          q_pri.insert(pos, pri);
          r.st = ST_OK;
        end
      end
      OP_POP_HI, OP_POP_LO: begin
        if (q_id.size() != 0) begin
          pos = (op == OP_POP_HI) ? 0 : q_id.size() - 1;
          r.id = q_id[pos];
          r.pri = q_pri[pos];
          q_id.delete(pos);
          q_pri.delete(pos);
          r.st = ST_OK;
        end
      end
      default: begin
        pos = -1;
        for (int k = 0; k < q_id.size(); k++)
          if (pos < 0 && q_id[k] == id) pos = k;
        if (pos >= 0) begin
          r.id = id;
          r.pri = q_pri[pos];
          q_id.delete(pos);
          q_pri.delete(pos);
          r.st = ST_OK;
        end
      end
    endcase
    r.occ = OCC_W'(q_id.size());
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_w.valid && in_w.ready)
        expected_words.push_back(apply_op(op_t'(in_w.op), in_w.item_id, in_w.priority_req));
      if (out_w.valid && out_w.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word id=%h pri=%h st=%0d occ=%0d", $time,
                   out_w.out_id, out_w.out_priority, out_w.status, out_w.occupancy);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.id !== out_w.out_id || e.pri !== out_w.out_priority ||
              e.st !== out_w.status || e.occ !== out_w.occupancy) begin
            $display("%0t: expected id=%h pri=%h st=%0d occ=%0d, got id=%h pri=%h st=%0d occ=%0d",
                     $time, e.id, e.pri, e.st, e.occ, out_w.out_id, out_w.out_priority,
                     out_w.status, out_w.occupancy);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_words.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

>>> test/sorted_priority_queue_tb.sv
// Testbench top: drives operation words, applies stalls and gives the verdict.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_off = 1'b0;
  bit   done = 1'b0;
  int   quiet_cycles = 0;
  int   sent = 0;

  spq_in_if  in_w ();
  spq_out_if out_w ();

  sorted_priority_queue uut (.clk(clk), .rst_n(rst_n), .in_w(in_w), .out_w(out_w));
  spq_checker chk (.clk(clk), .rst_n(rst_n), .in_w(in_w), .out_w(out_w),
                   .fail_count(fail_count), .pending(pending));

  always #6 clk = ~clk;

  initial begin
    in_w.valid = 1'b0;
    in_w.op = OP_INSERT;
    in_w.item_id = '0;
    in_w.priority_req = '0;
    out_w.ready = 1'b0;
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_w.ready <= 1'b0;
    else out_w.ready <= ($urandom_range(99) >= stall_pct);
  end

  // accept watchdog
  always @(posedge clk) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= spq_tb_pkg::WATCHDOG_LIMIT && !done) begin
      $display("sorted_priority_queue_tb NOT OK");
      $finish;
    end
  end

  // one word, with random idle gaps before it; valid stays up after accept
  task automatic send_word(op_t op, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    while ($urandom_range(99) < idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk);
    end
    in_w.valid <= 1'b1;
    in_w.op <= op;
    in_w.item_id <= id;
    in_w.priority_req <= pri;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_w.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || (in_w.valid)) @(posedge clk);
  endtask

  // ids drawn mostly from a small pool so removes hit
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(3))
      0: return ID_W'($urandom);
      default: return ID_W'($urandom_range(15));
    endcase
  endfunction

  task automatic random_phase(int n, int fill_bias);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < fill_bias)
        send_word(OP_INSERT, pick_id(), ($urandom_range(1) != 0) ? PRI_W'($urandom)
                                                                 : PRI_W'($urandom_range(3)));
      else if (r < fill_bias + (100 - fill_bias) / 3)
        send_word(OP_POP_HI, pick_id(), PRI_W'($urandom));
      else if (r < fill_bias + 2 * (100 - fill_bias) / 3)
        send_word(OP_POP_LO, pick_id(), PRI_W'($urandom));
      else
        send_word(OP_REMOVE, pick_id(), PRI_W'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extremes, equal priorities, duplicates, full
    send_word(OP_POP_HI, 16'h1234, 8'h00);
    send_word(OP_POP_LO, 16'h0000, 8'hff);
    send_word(OP_REMOVE, 16'hffff, 8'h00);
    send_word(OP_INSERT, 16'hffff, 8'hff);
    send_word(OP_INSERT, 16'h0000, 8'h00);
    send_word(OP_INSERT, 16'h0007, 8'h80);
    send_word(OP_INSERT, 16'h0008, 8'h80);
    send_word(OP_INSERT, 16'h0007, 8'h80);
    send_word(OP_REMOVE, 16'h0007, 8'h00);
    send_word(OP_REMOVE, 16'h5555, 8'h00);
    send_word(OP_POP_LO, 16'h0000, 8'h00);
    send_word(OP_POP_HI, 16'h0000, 8'h00);
    for (int i = 0; i < CAPACITY + 1; i++)
      send_word(OP_INSERT, ID_W'(i ^ 16'haaaa), PRI_W'(i % 3));
    send_word(OP_INSERT, 16'h5555, 8'h55);
    wait_drained();

    idle_pct = 0;  stall_pct = 0;  random_phase(400, 50);
    idle_pct = 59; stall_pct = 0;  random_phase(300, 60);
    idle_pct = 0;  stall_pct = 59; random_phase(300, 40);
    idle_pct = 28; stall_pct = 28; random_phase(300, 50);

    // long receiver hold-off while words keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        idle_pct = 0; stall_pct = 0;
        random_phase(60, 70);
        in_w.valid <= 1'b0;
        @(posedge clk);
      end
    join
    idle_pct = 10; stall_pct = 10; random_phase(300, 50);

    wait_drained();
    done = 1'b1;
    repeat (spq_tb_if_pkg::DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("sorted_priority_queue_tb OK");
    else
      $display("sorted_priority_queue_tb NOT OK");
    $finish;
  end

endmodule
